/* hdl/compacting_key_table_assert.svh */
// assertion macros for the compacting key table
// no dependencies; included by the top level
`ifndef COMPACTING_KEY_TABLE_ASSERT_SVH
`define COMPACTING_KEY_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CKT_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CKT_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* hdl/ckt_pkg.sv */
// shared types and codes for the compacting key table
// no dependencies
package ckt_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // search probe travelling down the chain
  typedef struct packed {
    logic valid;
    logic found;
  } probe_t;

  // broadcast control to every cell
  typedef struct packed {
    logic start;
    logic shift;
  } cell_ctrl_t;

endpackage

/* hdl/ckt_if.sv */
// request and response channels of the compacting key table
// no dependencies
interface ckt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] key_chars;
  logic [3:0]  key_length;

  modport source (output valid, operation, key_chars, key_length, input ready);
  modport sink   (input valid, operation, key_chars, key_length, output ready);
endinterface

interface ckt_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [1:0] status;
  logic [4:0] entry_count;

  modport source (output valid, found, status, entry_count, input ready);
  modport sink   (input valid, found, status, entry_count, output ready);
endinterface

/* hdl/compacting_key_table.sv */
// Compacting key table: a packed list of up to TABLE_ENTRIES keys of KEY_CHARS
// bytes each, held in a chain of cells. Add and the unused operation write or
// answer at once and pass through the done state to the output register. Lookup
// sends the key down the chain one cell per cycle; a remove that hits then passes
// through a shift state in which every cell at or after the match takes its
// neighbour's key. One request is in flight at a time; a new request is taken
// while the previous result still waits at the output.
// No clearing pass is needed after reset.
module compacting_key_table #(
  parameter int KEY_CHARS     = 8,
  parameter int TABLE_ENTRIES = 16
) (
  input logic       clk,
  input logic       rst,
  ckt_req_if.sink   req,
  ckt_rsp_if.source rsp
);
  import ckt_pkg::*;

  localparam int KEY_W = 8 * KEY_CHARS;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [1:0]         op_reg;
  logic               found_reg;
  logic [1:0]         status_reg;
  probe_t             inj;
  logic [KEY_W-1:0]   inj_key;
  logic [KEY_W-1:0]   norm_key;
  logic               accept;
  logic               full;
  logic               walk_end;
  logic               out_load;
  cell_ctrl_t         ctrl;
  logic               out_valid;
  logic               out_found;
  logic [1:0]         out_status;
  logic [CNT_W-1:0]   out_count;

  probe_t             probe_w  [0:TABLE_ENTRIES];
  logic [KEY_W-1:0]   key_w    [0:TABLE_ENTRIES];
  logic [KEY_W-1:0]   stored_w [0:TABLE_ENTRIES-1];

  assign accept = req.valid && req.ready;
  assign full   = (count == CNT_W'(TABLE_ENTRIES));

  // pad missing leading characters with ascii zero
  genvar b;
  generate
    for (b = 0; b < KEY_CHARS; b++) begin : g_norm
      assign norm_key[8*b +: 8] = (4'(b) < req.key_length) ? req.key_chars[8*b +: 8]
                                                           : PAD_CHAR;
    end
  endgenerate

  assign probe_w[0] = inj;
  assign key_w[0]   = inj_key;
  assign walk_end   = probe_w[TABLE_ENTRIES].valid;

  genvar i;
  generate
    for (i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      logic [KEY_W-1:0] nbr;
      if (i < TABLE_ENTRIES - 1) begin : g_mid
        assign nbr = stored_w[i+1];
      end else begin : g_last
        assign nbr = stored_w[i];
      end
      ckt_cell #(.KEY_W(KEY_W)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .in_range  (CNT_W'(i) < count),
        .load      (accept && (req.operation == OP_ADD) && !full && (count == CNT_W'(i))),
        .load_key  (norm_key),
        .next_key  (nbr),
        .probe_in  (probe_w[i]),
        .key_in    (key_w[i]),
        .probe_out (probe_w[i+1]),
        .key_out   (key_w[i+1]),
        .stored    (stored_w[i])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    ctrl       = '0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((req.operation == OP_REMOVE) || (req.operation == OP_LOOKUP)) begin
            ctrl.start = 1'b1;
            state_next = ST_WALK;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          if ((op_reg == OP_REMOVE) && probe_w[TABLE_ENTRIES].found) begin
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SHIFT: begin
        ctrl.shift = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      inj       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      inj.valid <= ctrl.start;
      inj.found <= 1'b0;
      if (accept && (req.operation == OP_ADD) && !full) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.shift) begin
        count <= count - CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg     <= req.operation;
      inj_key    <= norm_key;
      found_reg  <= 1'b0;
      status_reg <= ((req.operation == OP_ADD) && full) ? STAT_FULL : STAT_DONE;
    end else if ((state == ST_WALK) && walk_end) begin
      found_reg  <= probe_w[TABLE_ENTRIES].found;
      status_reg <= probe_w[TABLE_ENTRIES].found ? STAT_DONE : STAT_ABSENT;
    end
    if (out_load) begin
      out_found  <= found_reg;
      out_status <= status_reg;
      out_count  <= count;
    end
  end

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.status      = out_status;
  assign rsp.entry_count = 5'(out_count);

`include "compacting_key_table_assert.svh"

  `CKT_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(TABLE_ENTRIES), "count above table size")
  `CKT_ASSERT_IMPLY(a_shift_cause, clk, rst, state == ST_SHIFT, (op_reg == OP_REMOVE) && found_reg, "shift without a matching remove")
  `CKT_ASSERT_NEXT(a_shift_count, clk, rst, state == ST_SHIFT, count == $past(count) - CNT_W'(1), "remove did not drop the count")
  `CKT_ASSERT_NEXT(a_add_count, clk, rst, accept && (req.operation == OP_ADD) && !full, count == $past(count) + CNT_W'(1), "add did not raise the count")

endmodule

/* hdl/ckt_cell.sv */
// one table slot: holds a key, compares the passing probe, shifts down on removal
// depends on ckt_pkg
module ckt_cell #(
  parameter int KEY_W = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ckt_pkg::cell_ctrl_t ctrl,
  input  logic               in_range,
  input  logic               load,
  input  logic [KEY_W-1:0]   load_key,
  input  logic [KEY_W-1:0]   next_key,
  input  ckt_pkg::probe_t    probe_in,
  input  logic [KEY_W-1:0]   key_in,
  output ckt_pkg::probe_t    probe_out,
  output logic [KEY_W-1:0]   key_out,
  output logic [KEY_W-1:0]   stored
);
  import ckt_pkg::*;

  logic mark;
  logic hit;

  // only the first match in the chain claims the hit
  assign hit = probe_in.valid && !probe_in.found && in_range && (stored == key_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
      mark      <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
      probe_out.found <= probe_in.valid && (probe_in.found || hit);
      if (ctrl.start) begin
        mark <= 1'b0;
      end else if (probe_in.valid && (probe_in.found || hit)) begin
        mark <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_out <= key_in;
    if (load) begin
      stored <= load_key;
    end else if (ctrl.shift && mark) begin
      stored <= next_key;
    end
  end

endmodule
